// ----- sv/assert_macros.svh -----
// Assertion shorthands shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EAU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define EAU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/eau_pkg.sv -----
package eau_pkg;

    localparam int EAU_DATA_BITS     = 16;
    localparam int EAU_FRAC_BITS     = 12;
    localparam int EAU_TABLE_ENTRIES = 1024;

    localparam int SLOPE_BITS    = 16;
    localparam int KIND_BITS     = 3;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [SLOPE_BITS-1:0] SLOPE_RESET = 16'd655;

    typedef enum logic [KIND_BITS-1:0] {
        ACT_LINEAR  = 3'd0,
        ACT_RELU    = 3'd1,
        ACT_LEAKY   = 3'd2,
        ACT_SIGMOID = 3'd3,
        ACT_TANH    = 3'd4
    } t_act_kind;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_ACT_KIND   = 1'b0,
        CFG_LEAK_SLOPE = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic [KIND_BITS-1:0] kind;
        logic                 deriv;
    } t_op;

    // Restoring division, used only while building constant tables.
    function automatic logic [63:0] f_udiv(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Sigmoid sample i of a table spanning [0,8): exp(-t) from a short series on
    // t/256, squared eight times, then 1/(1+e) rounded to the nearest step.
    function automatic logic [63:0] f_sig_entry(input logic [63:0] idx, input int entries,
                                               input int frac);
        logic [63:0] q30;
        logic [63:0] tq;
        logic [63:0] r;
        logic [63:0] r2;
        logic [63:0] r3;
        logic [63:0] r4;
        logic [63:0] e;
        logic [63:0] d;
        q30 = 64'd1 << 30;
        tq  = f_udiv(idx << 33, 64'(entries));
        r   = tq >> 8;
        r2  = (r * r) >> 30;
        r3  = (r2 * r) >> 30;
        r4  = (r3 * r) >> 30;
        e   = q30 + (r2 >> 1) + r4 / 24 - r - r3 / 6;
        for (int k = 0; k < 8; k++) begin
            e = (e * e + (64'd1 << 29)) >> 30;
        end
        d = q30 + e;
        return f_udiv((64'd1 << frac) * q30 + (d >> 1), d);
    endfunction

endpackage

// ----- sv/eau_in_if.sv -----
interface eau_in_if import eau_pkg::*; #(
    parameter int DATA_BITS = EAU_DATA_BITS
) ();
    logic                        valid;
    logic                        ready;
    logic                        mode;
    logic signed [DATA_BITS-1:0] x;

    modport source (output valid, output mode, output x, input ready);
    modport sink   (input valid, input mode, input x, output ready);
endinterface

// ----- sv/eau_out_if.sv -----
interface eau_out_if import eau_pkg::*; #(
    parameter int DATA_BITS = EAU_DATA_BITS
) ();
    logic                        valid;
    logic                        ready;
    logic signed [DATA_BITS-1:0] y;

    modport source (output valid, output y, input ready);
    modport sink   (input valid, input y, output ready);
endinterface

// ----- sv/eau_cfg.sv -----
module eau_cfg import eau_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_we,
    input  logic [CFG_IDX_BITS-1:0]  i_idx,
    input  logic [CFG_DATA_BITS-1:0] i_data,
    output logic [KIND_BITS-1:0]     o_kind,
    output logic [SLOPE_BITS-1:0]    o_slope
);
    logic [KIND_BITS-1:0]  r_kind;
    logic [SLOPE_BITS-1:0] r_slope;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind  <= ACT_LINEAR;
            r_slope <= SLOPE_RESET;
        end else if (i_we) begin
            case (t_cfg_reg'(i_idx))
                CFG_ACT_KIND:   r_kind  <= i_data[KIND_BITS-1:0];
                CFG_LEAK_SLOPE: r_slope <= i_data[SLOPE_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign o_kind  = r_kind;
    assign o_slope = r_slope;
endmodule

// ----- sv/eau_sig_rom.sv -----
module eau_sig_rom import eau_pkg::*; #(
    parameter int DATA_BITS     = EAU_DATA_BITS,
    parameter int FRAC_BITS     = EAU_FRAC_BITS,
    parameter int TABLE_ENTRIES = EAU_TABLE_ENTRIES
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic signed [DATA_BITS-1:0] i_x,
    input  logic                        i_dbl,
    output logic [FRAC_BITS:0]          o_data,
    output logic                        o_neg
);
    localparam int SW = FRAC_BITS + 1;
    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int NB = $clog2(TABLE_ENTRIES + 1);
    localparam int PW = DATA_BITS + NB;

    typedef logic [SW-1:0] t_rom [TABLE_ENTRIES];

    function automatic t_rom f_build();
        t_rom rom;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            rom[i] = SW'(f_sig_entry(64'(i), TABLE_ENTRIES, FRAC_BITS));
        end
        return rom;
    endfunction

    localparam t_rom SIG_ROM = f_build();

    logic                        ovf;
    logic signed [DATA_BITS-1:0] x_dbl;
    logic signed [DATA_BITS-1:0] arg;
    logic                        neg;
    logic [DATA_BITS-1:0]        mag;
    logic [PW-1:0]               scaled;
    logic [IW-1:0]               idx;
    logic [SW-1:0]               r_data;
    logic                        r_neg;

    always_comb begin
        // doubled argument for tanh, clamped to the data range
        ovf = i_x[DATA_BITS-1] ^ i_x[DATA_BITS-2];
        if (ovf) begin
            x_dbl = i_x[DATA_BITS-1] ? {1'b1, {(DATA_BITS-1){1'b0}}}
                                     : {1'b0, {(DATA_BITS-1){1'b1}}};
        end else begin
            x_dbl = {i_x[DATA_BITS-2:0], 1'b0};
        end
        arg    = i_dbl ? x_dbl : i_x;
        neg    = arg[DATA_BITS-1];
        mag    = neg ? DATA_BITS'(-arg) : DATA_BITS'(arg);
        scaled = (PW'(mag) * PW'(TABLE_ENTRIES)) >> (FRAC_BITS + 3);
        if (scaled > PW'(TABLE_ENTRIES - 1)) begin
            idx = IW'(TABLE_ENTRIES - 1);
        end else begin
            idx = scaled[IW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= SIG_ROM[idx];
            r_neg  <= neg;
        end
    end

    assign o_data = r_data;
    assign o_neg  = r_neg;
endmodule

// ----- sv/eau_finish.sv -----
module eau_finish import eau_pkg::*; #(
    parameter int DATA_BITS = EAU_DATA_BITS,
    parameter int FRAC_BITS = EAU_FRAC_BITS
) (
    input  t_op                         i_op,
    input  logic signed [DATA_BITS-1:0] i_x,
    input  logic [FRAC_BITS:0]          i_rom,
    input  logic                        i_neg,
    input  logic [SLOPE_BITS-1:0]       i_slope,
    output logic signed [DATA_BITS-1:0] o_y
);
    localparam int SW  = FRAC_BITS + 1;
    localparam int TW  = FRAC_BITS + 3;
    localparam int YW  = ((DATA_BITS > FRAC_BITS + 2) ? DATA_BITS : FRAC_BITS + 2) + 1;
    localparam int LW  = DATA_BITS + SLOPE_BITS + 1;
    localparam int RSH = (FRAC_BITS <= SLOPE_BITS) ? SLOPE_BITS - FRAC_BITS : 0;
    localparam int LSH = (FRAC_BITS > SLOPE_BITS) ? FRAC_BITS - SLOPE_BITS : 0;
    localparam int DW2 = SLOPE_BITS + LSH;

    localparam logic [SW-1:0]        ONE_S = SW'(1) << FRAC_BITS;
    localparam logic signed [TW-1:0] ONE_T = TW'(ONE_S);
    localparam logic signed [YW-1:0] ONE_Y = YW'(ONE_S);
    localparam logic signed [YW-1:0] Y_MAX = YW'({(DATA_BITS-1){1'b1}});
    localparam logic signed [YW-1:0] Y_MIN = ~Y_MAX;

    logic [SW-1:0]          s;
    logic [SW-1:0]          s_comp;
    logic [2*SW-1:0]        sig_prod;
    logic signed [TW-1:0]   t;
    logic signed [2*TW-1:0] t_sq;
    logic signed [LW-1:0]   leak_prod;
    logic [DW2-1:0]         slope_q;
    logic signed [YW-1:0]   leak_fwd;
    logic signed [YW-1:0]   leak_der;
    logic signed [YW-1:0]   sig_der;
    logic signed [YW-1:0]   tanh_der;
    logic signed [YW-1:0]   x_w;
    logic signed [YW-1:0]   y_w;
    logic                   pos;

    always_comb begin
        // mirror the table for negative arguments
        s        = i_neg ? ONE_S - i_rom : i_rom;
        s_comp   = ONE_S - s;
        sig_prod = (2*SW)'(s) * (2*SW)'(s_comp);
        sig_der  = YW'(sig_prod >> FRAC_BITS);

        t        = $signed({1'b0, s, 1'b0}) - ONE_T;
        t_sq     = (2*TW)'(t) * (2*TW)'(t);
        tanh_der = ONE_Y - YW'(t_sq >>> FRAC_BITS);

        leak_prod = LW'(i_x) * LW'($signed({1'b0, i_slope}));
        leak_fwd  = YW'(leak_prod >>> SLOPE_BITS);
        // rescale the Q0.16 slope to the data fraction
        slope_q   = (DW2'(i_slope) << LSH) >> RSH;
        leak_der  = YW'(slope_q);

        pos = !i_x[DATA_BITS-1] && (i_x != '0);
        x_w = YW'(i_x);

        case (i_op.kind)
            ACT_RELU: begin
                if (pos) begin
                    y_w = i_op.deriv ? ONE_Y : x_w;
                end else begin
                    y_w = '0;
                end
            end
            ACT_LEAKY: begin
                if (pos) begin
                    y_w = i_op.deriv ? ONE_Y : x_w;
                end else begin
                    y_w = i_op.deriv ? leak_der : leak_fwd;
                end
            end
            ACT_SIGMOID: y_w = i_op.deriv ? sig_der : YW'(s);
            ACT_TANH:    y_w = i_op.deriv ? tanh_der : YW'(t);
            default:     y_w = i_op.deriv ? ONE_Y : x_w;
        endcase

        if (y_w > Y_MAX) begin
            o_y = DATA_BITS'(Y_MAX);
        end else if (y_w < Y_MIN) begin
            o_y = DATA_BITS'(Y_MIN);
        end else begin
            o_y = DATA_BITS'(y_w);
        end
    end
endmodule

// ----- sv/elementwise_activation_unit.sv -----
// A beat accepted into the input register moves on through the sigmoid table read register
// and then the result register, from which it is presented on the output.
// Throughput: one beat per cycle unless the output stalls; the registered table read port adds the middle stage.
// The input side stays ready while the result register is empty or being taken.
// Reset (synchronous, active low) empties all stages, selects linear and sets the
// leaky slope to 655; the table is constant, so no clearing pass follows.
module elementwise_activation_unit import eau_pkg::*; #(
    parameter int DATA_BITS     = EAU_DATA_BITS,
    parameter int FRAC_BITS     = EAU_FRAC_BITS,
    parameter int TABLE_ENTRIES = EAU_TABLE_ENTRIES
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    eau_in_if.sink                   i_in,
    eau_out_if.source                o_out
);
    logic [KIND_BITS-1:0]        kind;
    logic [SLOPE_BITS-1:0]       slope;
    logic                        advance;
    logic [FRAC_BITS:0]          rom_data;
    logic                        rom_neg;
    t_op                         op;
    logic signed [DATA_BITS-1:0] y_calc;

    logic                        r_a_valid;
    logic                        r_a_mode;
    logic signed [DATA_BITS-1:0] r_a_x;
    logic                        r_b_valid;
    logic                        r_b_mode;
    logic signed [DATA_BITS-1:0] r_b_x;
    logic                        r_c_valid;
    logic signed [DATA_BITS-1:0] r_c_y;

    eau_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_kind  (kind),
        .o_slope (slope)
    );

    // whole pipe moves while the result register is free or being drained
    assign advance    = !r_c_valid || o_out.ready;
    assign i_in.ready = advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else if (advance) begin
            r_a_valid <= i_in.valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_a_mode <= i_in.mode;
            r_a_x    <= i_in.x;
            r_b_mode <= r_a_mode;
            r_b_x    <= r_a_x;
            r_c_y    <= y_calc;
        end
    end

    eau_sig_rom #(
        .DATA_BITS     (DATA_BITS),
        .FRAC_BITS     (FRAC_BITS),
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_sig_rom (
        .i_clk  (i_clk),
        .i_en   (advance),
        .i_x    (r_a_x),
        .i_dbl  (kind == ACT_TANH),
        .o_data (rom_data),
        .o_neg  (rom_neg)
    );

    assign op = '{kind: kind, deriv: r_b_mode};

    eau_finish #(
        .DATA_BITS (DATA_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_finish (
        .i_op    (op),
        .i_x     (r_b_x),
        .i_rom   (rom_data),
        .i_neg   (rom_neg),
        .i_slope (slope),
        .o_y     (y_calc)
    );

    assign o_out.valid = r_c_valid;
    assign o_out.y     = r_c_y;

`include "assert_macros.svh"

    `EAU_ASSERT_NXT(a_accept_lands, i_clk, i_rst_n, i_in.valid && i_in.ready, r_a_valid, "accepted beat missing from input stage")
    `EAU_ASSERT_NXT(a_mid_to_out, i_clk, i_rst_n, r_b_valid && advance, o_out.valid, "beat dropped between table stage and output")
    `EAU_ASSERT_NXT(a_linear_pass, i_clk, i_rst_n, r_b_valid && advance && !r_b_mode && (kind == ACT_LINEAR), o_out.y == $past(r_b_x), "linear forward beat altered")
    `EAU_ASSERT_NXT(a_relu_nonneg, i_clk, i_rst_n, r_b_valid && advance && !r_b_mode && (kind == ACT_RELU), !o_out.y[DATA_BITS-1], "relu forward beat negative")
endmodule
